// File: hw/rtl/msp_pkg.sv
`default_nettype none
package msp_pkg;

  localparam int FRAME_TAIL  = 10;
  localparam int CMD_BYTES   = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [63:0] FRAME_RESET   = 64'd72340172856173577;
  localparam logic [15:0] SETTLE_RESET  = 16'd100;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [15:0] REST_RESET    = 16'd1000;

  // floor(x / 5) for x below 2**20: (x * 209715) >> 20 is low by at most one
  localparam logic [17:0] TEMP_RECIP  = 18'd209715;
  localparam int          TEMP_SHIFT  = 20;
  localparam logic [19:0] TEMP_DIV    = 20'd5;
  localparam logic [16:0] TEMP_OFFSET = 17'd320;

  typedef enum logic [1:0] {
    CFG_FRAME   = 2'd0,
    CFG_SETTLE  = 2'd1,
    CFG_TIMEOUT = 2'd2,
    CFG_REST    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_READING = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_SHORT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_SEND    = 2'd0,
    PH_SETTLE  = 2'd1,
    PH_COLLECT = 2'd2,
    PH_REST    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEND,
    BK_MUL,
    BK_FIX,
    BK_ONE
  } back_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] humidity_tenths;
    logic [16:0] temp_f_tenths;
    logic [15:0] conductivity;
    logic [15:0] ph_tenths;
  } out_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] hum;
    logic [15:0] temp_c;
    logic [15:0] cond;
    logic [15:0] ph;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/msp_queue.sv
`default_nettype none
module msp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  msp_pkg::job_t       push_job,
  input  wire logic           pop,
  output msp_pkg::job_t       pop_job,
  output msp_pkg::q_stat_t    stat
);

  localparam int PTR_W = $clog2(msp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(msp_pkg::QUEUE_DEPTH + 1);

  msp_pkg::job_t    mem_r [msp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(msp_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule
`default_nettype wire

// File: hw/rtl/msp_front.sv
`default_nettype none
module msp_front #(
  parameter int WINDOW_BYTES = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  msp_pkg::in_t     in_data,
  input  wire logic        q_full,
  input  wire logic [15:0] settle_ticks,
  input  wire logic [15:0] timeout_ticks,
  input  wire logic [15:0] rest_ticks,
  output logic             push,
  output msp_pkg::job_t    push_job
);

  localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
  localparam int BASE  = WINDOW_BYTES - msp_pkg::FRAME_TAIL;

  msp_pkg::phase_t  phase_r, phase_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       window_r [WINDOW_BYTES];

  logic accept;
  logic tick;
  logic have_bytes;

  assign accept     = in_valid && !q_full;
  assign tick       = accept && !in_data.mode;
  assign have_bytes = (count_r != '0);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    count_nxt   = count_r;
    if (accept && in_data.mode) begin
      if (count_r != CNT_W'(WINDOW_BYTES)) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (tick) begin
      unique case (phase_r)
        msp_pkg::PH_SEND: begin
          elapsed_nxt = '0;
          phase_nxt   = msp_pkg::PH_SETTLE;
        end
        msp_pkg::PH_SETTLE: begin
          if (elapsed_r >= settle_ticks) begin
            elapsed_nxt = '0;
            phase_nxt   = msp_pkg::PH_COLLECT;
          end else begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
        end
        msp_pkg::PH_COLLECT: begin
          if (have_bytes) begin
            count_nxt   = '0;
            elapsed_nxt = '0;
            phase_nxt   = msp_pkg::PH_REST;
          end else if (elapsed_r >= timeout_ticks) begin
            elapsed_nxt = '0;
            phase_nxt   = msp_pkg::PH_SEND;
          end else begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
        end
        msp_pkg::PH_REST: begin
          if (elapsed_r >= rest_ticks) begin
            elapsed_nxt = '0;
            phase_nxt   = msp_pkg::PH_SEND;
          end else begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
        end
        default: begin
          phase_nxt = msp_pkg::PH_SEND;
        end
      endcase
    end
  end

  // job issue
  always_comb begin
    push            = 1'b0;
    push_job.kind   = msp_pkg::KIND_TX;
    push_job.hum    = {window_r[BASE],     window_r[BASE + 1]};
    push_job.temp_c = {window_r[BASE + 2], window_r[BASE + 3]};
    push_job.cond   = {window_r[BASE + 4], window_r[BASE + 5]};
    push_job.ph     = {window_r[BASE + 6], window_r[BASE + 7]};
    if (tick) begin
      unique case (phase_r)
        msp_pkg::PH_SEND: begin
          push          = 1'b1;
          push_job.kind = msp_pkg::KIND_TX;
        end
        msp_pkg::PH_COLLECT: begin
          if (have_bytes) begin
            push = 1'b1;
            if (count_r < CNT_W'(msp_pkg::FRAME_TAIL)) begin
              push_job.kind = msp_pkg::KIND_SHORT;
            end else begin
              push_job.kind = msp_pkg::KIND_READING;
            end
          end else if (elapsed_r >= timeout_ticks) begin
            push          = 1'b1;
            push_job.kind = msp_pkg::KIND_TIMEOUT;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= msp_pkg::PH_SEND;
      elapsed_r <= '0;
      count_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      count_r   <= count_nxt;
    end
  end

  // newest byte at the top entry
  always_ff @(posedge clk) begin
    if (accept && in_data.mode) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
        window_r[i] <= window_r[i + 1];
      end
      window_r[WINDOW_BYTES - 1] <= in_data.rx_byte;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/msp_back.sv
`default_nettype none
module msp_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  msp_pkg::q_stat_t q_stat,
  input  msp_pkg::job_t    q_job,
  output logic             pop,
  input  wire logic [63:0] command_frame,
  output logic             out_valid,
  input  wire logic        out_stall,
  output msp_pkg::out_t    out_data
);

  msp_pkg::back_state_t state_r, state_nxt;
  logic [2:0]           idx_r, idx_nxt;
  msp_pkg::job_t        job_r, job_nxt;
  logic [16:0]          quo_r, quo_nxt;
  msp_pkg::out_t        out_r, out_nxt;
  logic                 out_valid_r;
  logic                 out_load;
  logic                 can_load;

  logic [19:0] temp_x;
  logic [37:0] prod;
  logic [19:0] five_q;
  logic [19:0] rem;
  logic [16:0] quo_fixed;
  logic [2:0]  sel;

  assign can_load  = !out_valid_r || !out_stall;
  assign temp_x    = {1'b0, job_r.temp_c, 3'b000} + {4'd0, job_r.temp_c};
  assign prod      = {18'd0, temp_x} * {20'd0, msp_pkg::TEMP_RECIP};
  assign five_q    = {1'b0, quo_r, 2'b00} + {3'd0, quo_r};
  assign rem       = temp_x - five_q;
  assign quo_fixed = (rem >= msp_pkg::TEMP_DIV) ? quo_r + 17'd1 : quo_r;
  assign sel       = 3'(msp_pkg::CMD_BYTES - 1) - idx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    job_nxt   = job_r;
    quo_nxt   = quo_r;
    unique case (state_r)
      msp_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          job_nxt = q_job;
          idx_nxt = '0;
          unique case (q_job.kind)
            msp_pkg::KIND_TX:      state_nxt = msp_pkg::BK_SEND;
            msp_pkg::KIND_READING: state_nxt = msp_pkg::BK_MUL;
            default:               state_nxt = msp_pkg::BK_ONE;
          endcase
        end
      end
      msp_pkg::BK_SEND: begin
        if (can_load) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'(msp_pkg::CMD_BYTES - 1)) begin
            state_nxt = msp_pkg::BK_IDLE;
          end
        end
      end
      msp_pkg::BK_MUL: begin
        quo_nxt   = prod[msp_pkg::TEMP_SHIFT +: 17];
        state_nxt = msp_pkg::BK_FIX;
      end
      msp_pkg::BK_FIX: begin
        if (can_load) begin
          state_nxt = msp_pkg::BK_IDLE;
        end
      end
      msp_pkg::BK_ONE: begin
        if (can_load) begin
          state_nxt = msp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = msp_pkg::BK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    out_nxt  = '0;
    unique case (state_r)
      msp_pkg::BK_IDLE: begin
        pop = !q_stat.empty;
      end
      msp_pkg::BK_SEND: begin
        out_load        = can_load;
        out_nxt.kind    = msp_pkg::KIND_TX;
        out_nxt.tx_byte = command_frame[8 * sel +: 8];
        out_nxt.last    = (idx_r == 3'(msp_pkg::CMD_BYTES - 1));
      end
      msp_pkg::BK_FIX: begin
        out_load                = can_load;
        out_nxt.kind            = msp_pkg::KIND_READING;
        out_nxt.last            = 1'b1;
        out_nxt.humidity_tenths = job_r.hum;
        out_nxt.temp_f_tenths   = quo_fixed + msp_pkg::TEMP_OFFSET;
        out_nxt.conductivity    = job_r.cond;
        out_nxt.ph_tenths       = job_r.ph;
      end
      msp_pkg::BK_ONE: begin
        out_load     = can_load;
        out_nxt.kind = job_r.kind;
        out_nxt.last = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msp_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    job_r <= job_nxt;
    quo_r <= quo_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: hw/rtl/modbus_sensor_poller.sv
// modbus_sensor_poller: polls a serial soil sensor in a send, settle, collect, rest loop.
// input channel (in_valid / in_stall / in_data): one beat is a millisecond tick
//   (mode 0) or a received serial byte (mode 1). beats are taken one per cycle
//   while the four-entry job queue between front and back has room.
// result channel (out_valid / out_stall / out_data): a tick in the send phase
//   gives a run of eight transmit beats, last set on the eighth; a decode gives
//   one reading or short-frame beat, a collect timeout one timeout beat.
// configuration (cfg_we / cfg_index / cfg_data): command frame, settle, timeout
//   and rest tick counts, written by the user only while the block is idle; the block
//   itself does not enforce this.
// each job passes from the front through the queue and the back end's idle state,
//   which fetches it, into the output register; a transmit run then gives one beat
//   a cycle unless out_stall holds. a reading first passes the multiply state, which
//   multiplies by a reciprocal, and the fix state, which applies a correction.
// a stalled result holds in the output register while the front keeps taking
//   beats until the queue fills; then in_stall rises.
// reset: configuration returns to its defaults, the loop to the send phase,
//   the byte count to zero and the queue and output to empty.
`default_nettype none
module modbus_sensor_poller #(
  parameter int WINDOW_BYTES = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  msp_pkg::in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output msp_pkg::out_t    out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0] frame_r;
  logic [15:0] settle_r;
  logic [15:0] timeout_r;
  logic [15:0] rest_r;

  logic             push;
  msp_pkg::job_t    push_job;
  logic             pop;
  msp_pkg::job_t    pop_job;
  msp_pkg::q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= msp_pkg::FRAME_RESET;
      settle_r  <= msp_pkg::SETTLE_RESET;
      timeout_r <= msp_pkg::TIMEOUT_RESET;
      rest_r    <= msp_pkg::REST_RESET;
    end else if (cfg_we) begin
      unique case (msp_pkg::cfg_idx_t'(cfg_index))
        msp_pkg::CFG_FRAME:   frame_r   <= cfg_data;
        msp_pkg::CFG_SETTLE:  settle_r  <= cfg_data[15:0];
        msp_pkg::CFG_TIMEOUT: timeout_r <= cfg_data[15:0];
        msp_pkg::CFG_REST:    rest_r    <= cfg_data[15:0];
        default:              frame_r   <= frame_r;
      endcase
    end
  end

  assign in_stall = q_stat.full;

  msp_front #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .q_full        (q_stat.full),
    .settle_ticks  (settle_r),
    .timeout_ticks (timeout_r),
    .rest_ticks    (rest_r),
    .push          (push),
    .push_job      (push_job)
  );

  msp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  msp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_job         (pop_job),
    .pop           (pop),
    .command_frame (frame_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != msp_pkg::KIND_TX) |-> out_data.last)
    else $error("non-transmit result without last");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == msp_pkg::KIND_READING) |->
      (out_data.temp_f_tenths >= 17'd320) && (out_data.temp_f_tenths <= 17'd118283))
    else $error("temperature out of range");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("job pushed into a full queue");

  a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

endmodule
`default_nettype wire
